// ----- sv/config_text_lexer_macros.svh -----
// Assertion shorthands for the lexer checkers.
// Each expects i_clk and i_rst_n in the enclosing scope.
`ifndef CONFIG_TEXT_LEXER_MACROS_SVH
`define CONFIG_TEXT_LEXER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CTL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define CTL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/ctl_pkg.sv -----
`timescale 1ns / 1ps

package ctl_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_DIGITS    = 31;
    localparam int DEF_POSITION_BITS = 32;
    localparam int DEF_LINE_BITS     = 24;
    localparam int DEF_COLUMN_BITS   = 16;

    // Fixed field widths of the channels
    localparam int BYTE_W   = 8;
    localparam int KIND_W   = 4;
    localparam int START_W  = 32;
    localparam int LENGTH_W = 32;
    localparam int LINE_W   = 24;
    localparam int COL_W    = 16;
    localparam int VALUE_W  = 64;

    // One byte raises at most this many tokens
    localparam int MAX_RESULTS = 3;
    localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    typedef enum logic [KIND_W-1:0] {
        K_END      = 4'd0,
        K_NEWLINE  = 4'd1,
        K_LBRACE   = 4'd2,
        K_RBRACE   = 4'd3,
        K_LBRACKET = 4'd4,
        K_RBRACKET = 4'd5,
        K_EQUALS   = 4'd6,
        K_COLON    = 4'd7,
        K_COMMA    = 4'd8,
        K_STRING   = 4'd9,
        K_NUMBER   = 4'd10,
        K_IDENT    = 4'd11,
        K_ERROR    = 4'd12
    } t_kind;

    typedef enum logic [2:0] {
        M_IDLE,
        M_COMMENT,
        M_STRING,
        M_STRING_ESC,
        M_ZERO,
        M_DEC,
        M_HEX,
        M_IDENT
    } t_mode;

    typedef struct packed {
        t_kind                kind;
        logic [START_W-1:0]   start;
        logic [LENGTH_W-1:0]  length;
        logic [LINE_W-1:0]    line;
        logic [COL_W-1:0]     column;
        logic [VALUE_W-1:0]   value;
    } t_token;

    // Tokens raised by one byte, slot 0 delivered first
    typedef struct packed {
        logic [RCNT_W-1:0]             count;
        t_token [MAX_RESULTS-1:0]      slot;
    } t_bundle;

endpackage

// ----- sv/ctl_intf.sv -----
`timescale 1ns / 1ps

interface ctl_byte_if import ctl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

interface ctl_token_if import ctl_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   token_kind;
    logic [START_W-1:0]  token_start;
    logic [LENGTH_W-1:0] token_length;
    logic [LINE_W-1:0]   token_line;
    logic [COL_W-1:0]    token_column;
    logic [VALUE_W-1:0]  number_value;
    logic                run_end;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output token_line, output token_column, output number_value, output run_end,
        input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input token_line, input token_column, input number_value, input run_end,
        output ready
    );
endinterface

// ----- sv/ctl_scan.sv -----
`timescale 1ns / 1ps

module ctl_scan import ctl_pkg::*; #(
    parameter int MAX_DIGITS    = DEF_MAX_DIGITS,
    parameter int POSITION_BITS = DEF_POSITION_BITS,
    parameter int LINE_BITS     = DEF_LINE_BITS,
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_last,
    output t_bundle           o_bundle
);

    localparam int DCNT_W = $clog2(MAX_DIGITS + 1);
    localparam int ACC_W  = VALUE_W + 4;

    localparam logic [BYTE_W-1:0] CH_NUL      = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE    = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH     = 8'h23;
    localparam logic [BYTE_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DASH     = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_0        = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9        = 8'h39;
    localparam logic [BYTE_W-1:0] CH_COLON    = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_EQUALS   = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_UP_A     = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UP_F     = 8'h46;
    localparam logic [BYTE_W-1:0] CH_UP_X     = 8'h58;
    localparam logic [BYTE_W-1:0] CH_UP_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_BSLASH   = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_RBRACKET = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_USCORE   = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_LOW_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOW_F    = 8'h66;
    localparam logic [BYTE_W-1:0] CH_LOW_X    = 8'h78;
    localparam logic [BYTE_W-1:0] CH_LOW_Z    = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_LBRACE   = 8'h7B;
    localparam logic [BYTE_W-1:0] CH_RBRACE   = 8'h7D;
    localparam logic [BYTE_W-1:0] HEX_LETTER  = 8'd10;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [LENGTH_W-1:0]    LEN_MAX  = '1;

    // Lexer state
    t_mode                    r_mode,   n_mode;
    logic [POSITION_BITS-1:0] r_pos,    n_pos;
    logic [LINE_BITS-1:0]     r_line,   n_line;
    logic [COLUMN_BITS-1:0]   r_col,    n_col;
    logic [POSITION_BITS-1:0] r_pstart, n_pstart;
    logic [LINE_BITS-1:0]     r_pline,  n_pline;
    logic [COLUMN_BITS-1:0]   r_pcol,   n_pcol;
    logic [VALUE_W-1:0]       r_acc,    n_acc;
    logic [DCNT_W-1:0]        r_dcnt,   n_dcnt;
    logic                     r_ovf,    n_ovf;
    logic [LENGTH_W-1:0]      r_blen,   n_blen;

    // State after this byte, before the end-of-text flush
    t_mode                    w_mode;
    logic [POSITION_BITS-1:0] w_pstart, w_pos;
    logic [LINE_BITS-1:0]     w_pline,  w_line;
    logic [COLUMN_BITS-1:0]   w_pcol,   w_col;
    logic [VALUE_W-1:0]       w_acc;
    logic [DCNT_W-1:0]        w_dcnt;
    logic                     w_ovf;
    logic [LENGTH_W-1:0]      w_blen;

    logic w_handled, w_flush, w_close;

    // Byte classes
    logic        c_digit, c_alpha, c_istart, c_imore, c_hex, c_space, c_break, c_punct;
    t_kind       c_pkind;
    logic [3:0]  c_hexval;
    logic [BYTE_W-1:0] c_letter;

    // Accumulate step
    logic [3:0]       a_digit;
    logic [ACC_W-1:0] a_sum;
    logic             a_full;
    logic [LENGTH_W-1:0] w_blen_inc;

    function automatic t_token flush_tok(
        input t_mode                    m,
        input logic [POSITION_BITS-1:0] ps,
        input logic [LINE_BITS-1:0]     pl,
        input logic [COLUMN_BITS-1:0]   pc,
        input logic [LENGTH_W-1:0]      blen,
        input logic [DCNT_W-1:0]        dcnt,
        input logic                     ovf,
        input logic [VALUE_W-1:0]       acc
    );
        t_token t;
        t.kind   = K_ERROR;
        t.start  = START_W'(ps);
        t.length = blen;
        t.line   = LINE_W'(pl);
        t.column = COL_W'(pc);
        t.value  = '0;
        case (m)
            M_IDENT: begin
                t.kind = K_IDENT;
            end
            M_ZERO, M_DEC, M_HEX: begin
                t.length = LENGTH_W'(dcnt);
                if (!ovf && (dcnt != '0)) begin
                    t.kind  = K_NUMBER;
                    t.value = acc;
                end
            end
            default: begin
            end
        endcase
        return t;
    endfunction

    always_comb begin : classify
        c_digit  = (i_byte >= CH_0) && (i_byte <= CH_9);
        c_alpha  = ((i_byte >= CH_LOW_A) && (i_byte <= CH_LOW_Z))
                || ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_Z));
        c_istart = c_alpha || (i_byte == CH_USCORE) || (i_byte == CH_DOT);
        c_imore  = c_istart || c_digit || (i_byte == CH_DASH);
        c_space  = (i_byte == CH_SPACE) || (i_byte == CH_TAB) || (i_byte == CH_CR);
        c_break  = (i_byte == CH_LF) || (i_byte == CH_CR) || (i_byte == CH_NUL);
        c_hex    = c_digit || ((i_byte >= CH_LOW_A) && (i_byte <= CH_LOW_F))
                || ((i_byte >= CH_UP_A) && (i_byte <= CH_UP_F));
        if (i_byte >= CH_LOW_A) begin
            c_letter = i_byte - CH_LOW_A + HEX_LETTER;
        end else begin
            c_letter = i_byte - CH_UP_A + HEX_LETTER;
        end
        if (c_digit) begin
            c_hexval = 4'(i_byte - CH_0);
        end else begin
            c_hexval = c_letter[3:0];
        end
        c_punct = 1'b1;
        case (i_byte)
            CH_LF:       c_pkind = K_NEWLINE;
            CH_LBRACE:   c_pkind = K_LBRACE;
            CH_RBRACE:   c_pkind = K_RBRACE;
            CH_LBRACKET: c_pkind = K_LBRACKET;
            CH_RBRACKET: c_pkind = K_RBRACKET;
            CH_EQUALS:   c_pkind = K_EQUALS;
            CH_COLON:    c_pkind = K_COLON;
            CH_COMMA:    c_pkind = K_COMMA;
            default: begin
                c_pkind = K_ERROR;
                c_punct = 1'b0;
            end
        endcase
    end

    // One shift-add of the number accumulator; base 16 in hex mode, else 10
    always_comb begin : accumulate
        a_digit = (r_mode == M_HEX) ? c_hexval : 4'(i_byte - CH_0);
        if (r_mode == M_HEX) begin
            a_sum = {r_acc, 4'b0000} + ACC_W'(a_digit);
        end else begin
            a_sum = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + ACC_W'(a_digit);
        end
        a_full     = (r_dcnt >= DCNT_W'(MAX_DIGITS));
        w_blen_inc = (r_blen != LEN_MAX) ? r_blen + 1'b1 : r_blen;
    end

    always_comb begin : next_state
        w_handled = 1'b0;
        w_flush   = 1'b0;
        w_close   = 1'b0;
        w_mode    = r_mode;
        w_pstart  = r_pstart;
        w_pline   = r_pline;
        w_pcol    = r_pcol;
        w_acc     = r_acc;
        w_dcnt    = r_dcnt;
        w_ovf     = r_ovf;
        w_blen    = r_blen;

        // Continue the token in progress
        case (r_mode)
            M_COMMENT: begin
                if (i_byte == CH_LF) begin
                    w_mode = M_IDLE;
                end else begin
                    w_handled = 1'b1;
                end
            end
            M_STRING, M_STRING_ESC: begin
                if (c_break) begin
                    w_flush = 1'b1;
                    w_mode  = M_IDLE;
                end else if (r_mode == M_STRING_ESC) begin
                    w_mode    = M_STRING;
                    w_blen    = w_blen_inc;
                    w_handled = 1'b1;
                end else if (i_byte == CH_QUOTE) begin
                    w_close   = 1'b1;
                    w_mode    = M_IDLE;
                    w_handled = 1'b1;
                end else begin
                    if (i_byte == CH_BSLASH) begin
                        w_mode = M_STRING_ESC;
                    end
                    w_blen    = w_blen_inc;
                    w_handled = 1'b1;
                end
            end
            M_ZERO, M_DEC, M_HEX: begin
                if ((r_mode == M_ZERO) && ((i_byte == CH_LOW_X) || (i_byte == CH_UP_X))) begin
                    // Hex body starts after the prefix; keep line and column of the 0
                    w_pstart  = r_pos + 1'b1;
                    w_acc     = '0;
                    w_dcnt    = '0;
                    w_ovf     = 1'b0;
                    w_blen    = '0;
                    w_mode    = M_HEX;
                    w_handled = 1'b1;
                end else if ((r_mode == M_HEX) ? c_hex : c_digit) begin
                    if (r_mode == M_ZERO) begin
                        w_mode = M_DEC;
                    end
                    if (a_full) begin
                        w_ovf = 1'b1;
                    end else begin
                        w_dcnt = r_dcnt + 1'b1;
                        w_acc  = a_sum[VALUE_W-1:0];
                        w_ovf  = r_ovf || (a_sum[ACC_W-1:VALUE_W] != '0);
                    end
                    w_handled = 1'b1;
                end else begin
                    w_flush = 1'b1;
                    w_mode  = M_IDLE;
                end
            end
            M_IDENT: begin
                if (c_imore) begin
                    w_blen    = w_blen_inc;
                    w_handled = 1'b1;
                end else begin
                    w_flush = 1'b1;
                    w_mode  = M_IDLE;
                end
            end
            default: begin
                w_mode = M_IDLE;
            end
        endcase

        // Lex the byte afresh
        if (!w_handled) begin
            if (i_byte == CH_HASH) begin
                w_mode = M_COMMENT;
            end else if (i_byte == CH_QUOTE) begin
                w_pstart = r_pos + 1'b1;
                w_pline  = r_line;
                w_pcol   = r_col;
                w_acc    = '0;
                w_dcnt   = '0;
                w_ovf    = 1'b0;
                w_blen   = '0;
                w_mode   = M_STRING;
            end else if (c_digit) begin
                w_pstart = r_pos;
                w_pline  = r_line;
                w_pcol   = r_col;
                w_acc    = VALUE_W'(a_digit);
                w_dcnt   = DCNT_W'(1);
                w_ovf    = 1'b0;
                w_blen   = '0;
                w_mode   = (i_byte == CH_0) ? M_ZERO : M_DEC;
            end else if (c_istart) begin
                w_pstart = r_pos;
                w_pline  = r_line;
                w_pcol   = r_col;
                w_acc    = '0;
                w_dcnt   = '0;
                w_ovf    = 1'b0;
                w_blen   = LENGTH_W'(1);
                w_mode   = M_IDENT;
            end
        end

        w_pos = r_pos + 1'b1;
        if (i_byte == CH_LF) begin
            w_line = (r_line != LINE_MAX) ? r_line + 1'b1 : r_line;
            w_col  = COLUMN_BITS'(1);
        end else begin
            w_line = r_line;
            w_col  = (r_col != COL_MAX) ? r_col + 1'b1 : r_col;
        end

        // End of text drops everything back to the reset state
        if (i_last) begin
            n_mode   = M_IDLE;
            n_pos    = '0;
            n_line   = LINE_BITS'(1);
            n_col    = COLUMN_BITS'(1);
            n_pstart = '0;
            n_pline  = LINE_BITS'(1);
            n_pcol   = COLUMN_BITS'(1);
            n_acc    = '0;
            n_dcnt   = '0;
            n_ovf    = 1'b0;
            n_blen   = '0;
        end else begin
            n_mode   = w_mode;
            n_pos    = w_pos;
            n_line   = w_line;
            n_col    = w_col;
            n_pstart = w_pstart;
            n_pline  = w_pline;
            n_pcol   = w_pcol;
            n_acc    = w_acc;
            n_dcnt   = w_dcnt;
            n_ovf    = w_ovf;
            n_blen   = w_blen;
        end
    end

    always_comb begin : outputs
        t_token             cand   [4];
        logic               cand_v [4];
        logic [RCNT_W-1:0]  cnt;

        // Closed string or flushed token from before this byte
        cand_v[0] = w_flush || w_close;
        cand[0]   = flush_tok(r_mode, r_pstart, r_pline, r_pcol, r_blen, r_dcnt, r_ovf,
                              r_acc);
        if (w_close) begin
            cand[0].kind = K_STRING;
        end

        // One-byte token or bad byte
        cand_v[1]       = !w_handled && !c_space && (i_byte != CH_HASH)
                       && (i_byte != CH_QUOTE) && !c_digit && !c_istart;
        cand[1].kind    = c_punct ? c_pkind : K_ERROR;
        cand[1].start   = START_W'(r_pos);
        cand[1].length  = LENGTH_W'(1);
        cand[1].line    = LINE_W'(r_line);
        cand[1].column  = COL_W'(r_col);
        cand[1].value   = '0;

        // Token still open at end of text
        cand_v[2] = i_last && (w_mode != M_IDLE) && (w_mode != M_COMMENT);
        cand[2]   = flush_tok(w_mode, w_pstart, w_pline, w_pcol, w_blen, w_dcnt, w_ovf,
                              w_acc);

        cand_v[3]       = i_last;
        cand[3].kind    = K_END;
        cand[3].start   = START_W'(w_pos);
        cand[3].length  = '0;
        cand[3].line    = LINE_W'(w_line);
        cand[3].column  = COL_W'(w_col);
        cand[3].value   = '0;

        cnt           = '0;
        o_bundle.slot = '0;
        for (int i = 0; i < 4; i++) begin
            if (cand_v[i] && (cnt < RCNT_W'(MAX_RESULTS))) begin
                o_bundle.slot[IDX_W'(cnt)] = cand[i];
                cnt = cnt + 1'b1;
            end
        end
        o_bundle.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_line   <= LINE_BITS'(1);
            r_col    <= COLUMN_BITS'(1);
            r_pstart <= '0;
            r_pline  <= LINE_BITS'(1);
            r_pcol   <= COLUMN_BITS'(1);
            r_acc    <= '0;
            r_dcnt   <= '0;
            r_ovf    <= 1'b0;
            r_blen   <= '0;
        end else if (i_step) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_line   <= n_line;
            r_col    <= n_col;
            r_pstart <= n_pstart;
            r_pline  <= n_pline;
            r_pcol   <= n_pcol;
            r_acc    <= n_acc;
            r_dcnt   <= n_dcnt;
            r_ovf    <= n_ovf;
            r_blen   <= n_blen;
        end
    end

endmodule

// ----- sv/ctl_drain.sv -----
`timescale 1ns / 1ps

module ctl_drain import ctl_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  t_bundle            i_bundle,
    output logic               o_free,
    ctl_token_if.source        o_tok
);

    t_token [MAX_RESULTS-1:0] r_slot;
    logic [RCNT_W-1:0]        r_count, n_count;
    logic [IDX_W-1:0]         r_idx,   n_idx;
    t_token                   w_tok;
    logic                     w_last, w_take;

    assign w_tok  = r_slot[r_idx];
    assign w_last = (r_idx == IDX_W'(r_count - RCNT_W'(1)));
    assign w_take = o_tok.valid && o_tok.ready;
    assign o_free = (r_count == '0) || (w_take && w_last);

    assign o_tok.valid        = (r_count != '0);
    assign o_tok.token_kind   = w_tok.kind;
    assign o_tok.token_start  = w_tok.start;
    assign o_tok.token_length = w_tok.length;
    assign o_tok.token_line   = w_tok.line;
    assign o_tok.token_column = w_tok.column;
    assign o_tok.number_value = w_tok.value;
    assign o_tok.run_end      = w_last;

    always_comb begin
        n_count = r_count;
        n_idx   = r_idx;
        if (i_load) begin
            n_count = i_bundle.count;
            n_idx   = '0;
        end else if (w_take) begin
            if (w_last) begin
                n_count = '0;
            end else begin
                n_idx = r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_bundle.slot;
        end
    end

endmodule

// ----- sv/config_text_lexer.sv -----
`timescale 1ns / 1ps
// Streaming lexer for key/value configuration text.
// i_text carries one text byte per transaction, with last_byte marking the
// final byte of a text. o_token carries one token per transaction: kind,
// body offset and length, line and column, number value, and run_end on the
// last token that a byte raises. A byte raises zero to three tokens.
// Path: an accepted byte is held in the input register; the tokens it
// raises are loaded into the result register, which drives o_token.
// Throughput: one byte per cycle while each byte raises at most one token
// and the receiver is ready; the single result register hands out the tokens
// of a byte one token per cycle while the receiver is ready.
// Stall: a byte waits in the input register while the receiver stalls, so
// one more byte is taken behind a waiting token; after that i_text.ready
// drops until the tokens are taken. Nothing is dropped.
// Reset (synchronous, i_rst_n low): both registers empty, scanner idle at
// offset 0, line 1, column 1. The end token of a text returns the scanner
// to that same state, so the next byte starts a new text.
module config_text_lexer import ctl_pkg::*; #(
    parameter int MAX_DIGITS    = DEF_MAX_DIGITS,     // 20 to 63
    parameter int POSITION_BITS = DEF_POSITION_BITS,  // 16 to 48
    parameter int LINE_BITS     = DEF_LINE_BITS,      // 8 to 32
    parameter int COLUMN_BITS   = DEF_COLUMN_BITS     // 8 to 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctl_byte_if.sink     i_text,
    ctl_token_if.source  o_token
);

    // Input register: holds one byte until the result register can take
    // everything the byte raises.
    logic              r_in_valid, n_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    logic    w_free;    // result register empty or emptying this cycle
    logic    w_step;    // the held byte is lexed and its tokens loaded
    t_bundle w_bundle;

    assign w_step       = r_in_valid && w_free;
    assign i_text.ready = !r_in_valid || w_free;

    always_comb begin
        n_in_valid = r_in_valid;
        if (i_text.valid && i_text.ready) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // Capture the payload of each accepted transaction
    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_byte <= i_text.text_byte;
            r_last <= i_text.last_byte;
        end
    end

    // Scanner: mode, position and pending-token state; advance once per byte
    ctl_scan #(
        .MAX_DIGITS    (MAX_DIGITS),
        .POSITION_BITS (POSITION_BITS),
        .LINE_BITS     (LINE_BITS),
        .COLUMN_BITS   (COLUMN_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_byte   (r_byte),
        .i_last   (r_last),
        .o_bundle (w_bundle)
    );

    // Result register: hold the tokens of one byte and hand them out in order
    ctl_drain u_drain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_step),
        .i_bundle (w_bundle),
        .o_free   (w_free),
        .o_tok    (o_token)
    );

endmodule

// ----- sv/ctl_check.sv -----
`timescale 1ns / 1ps
`include "config_text_lexer_macros.svh"

module ctl_check import ctl_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_tok_valid,
    input logic                i_tok_ready,
    input logic [KIND_W-1:0]   i_tok_kind,
    input logic [START_W-1:0]  i_tok_start,
    input logic [LENGTH_W-1:0] i_tok_length,
    input logic [LINE_W-1:0]   i_tok_line,
    input logic [COL_W-1:0]    i_tok_column,
    input logic [VALUE_W-1:0]  i_tok_value,
    input logic                i_tok_run_end
);

    // A stalled token holds
    `CTL_ASSERT_NXT(a_stall_hold, i_tok_valid && !i_tok_ready, i_tok_valid && $stable(i_tok_kind) && $stable(i_tok_start) && $stable(i_tok_length) && $stable(i_tok_line) && $stable(i_tok_column) && $stable(i_tok_value) && $stable(i_tok_run_end), "stalled token changed")

    // Only number tokens carry a value
    `CTL_ASSERT_NOW(a_value_zero, i_tok_valid && (i_tok_kind != K_NUMBER), i_tok_value == '0, "value on a non-number token")

    // End token closes the run of its byte and has an empty body
    `CTL_ASSERT_NOW(a_end_last, i_tok_valid && (i_tok_kind == K_END), i_tok_run_end && (i_tok_length == '0), "end token not last or not empty")

    // One-byte tokens are one byte long
    `CTL_ASSERT_NOW(a_punct_len, i_tok_valid && (i_tok_kind >= K_NEWLINE) && (i_tok_kind <= K_COMMA), i_tok_length == LENGTH_W'(1), "one-byte token with wrong length")

endmodule

bind config_text_lexer ctl_check u_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_tok_valid   (o_token.valid),
    .i_tok_ready   (o_token.ready),
    .i_tok_kind    (o_token.token_kind),
    .i_tok_start   (o_token.token_start),
    .i_tok_length  (o_token.token_length),
    .i_tok_line    (o_token.token_line),
    .i_tok_column  (o_token.token_column),
    .i_tok_value   (o_token.number_value),
    .i_tok_run_end (o_token.run_end)
);
